>>> hw/rtl/subrecord_tlv_deframer_defines.svh
// ----------------------------------------------------------------------------
// subrecord_tlv_deframer_defines
// assertion macros used by the deframer checker
// ----------------------------------------------------------------------------
`ifndef SUBRECORD_TLV_DEFRAMER_DEFINES_SVH
`define SUBRECORD_TLV_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define STLVD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stlvd same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define STLVD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stlvd next-cycle check failed");

`endif

>>> hw/rtl/stlvd_pkg.sv
// ----------------------------------------------------------------------------
// stlvd_pkg
// types and constants of the subrecord tlv deframer
// ----------------------------------------------------------------------------
`default_nettype none

package stlvd_pkg;

  localparam int LEN_W  = 27;
  localparam int OFF_W  = 26;
  localparam int TYPE_W = 32;
  localparam int XS_W   = 32;
  localparam int SS_W   = 16;
  localparam int CNT_W  = 3;

  localparam logic [LEN_W-1:0]  MAX_RECORD_LEN = LEN_W'(67108864);
  localparam logic [LEN_W-1:0]  LEN_SAT        = {LEN_W{1'b1}};
  localparam logic [TYPE_W-1:0] MARKER_TYPE    = 32'h5858_5858;
  localparam logic [LEN_W-1:0]  HDR_BYTES      = LEN_W'(6);
  localparam logic [LEN_W-1:0]  XSIZE_BYTES    = LEN_W'(4);
  localparam logic [SS_W-1:0]   MARKER_SIZE    = SS_W'(4);
  localparam logic [CNT_W-1:0]  HDR_LAST       = CNT_W'(5);
  localparam logic [CNT_W-1:0]  XSIZE_LAST     = CNT_W'(3);
  localparam logic [CNT_W-1:0]  TYPE_BYTES     = CNT_W'(4);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_BAD_SIZE = 3'd2,
    KIND_TRUNC    = 3'd3,
    KIND_OVERRUN  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_XSIZE  = 3'd2,
    PH_BODY   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [LEN_W-1:0] record_len;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [TYPE_W-1:0] sub_type;
    logic [LEN_W-1:0]  sub_len;
    logic [OFF_W-1:0]  byte_offset;
    logic [7:0]        byte_value;
    logic              last_of_sub;
  } res_t;

  // slave tdata layout, lowest bit first: record_len, data_byte
  typedef struct packed {
    logic [4:0]       pad;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] record_len;
  } in_data_t;

  // master tdata layout, lowest bit first: sub_type, sub_len, byte_offset, byte_value
  typedef struct packed {
    logic [2:0]        pad;
    logic [7:0]        byte_value;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  sub_len;
    logic [TYPE_W-1:0] sub_type;
  } out_data_t;

endpackage

`default_nettype wire

>>> hw/rtl/stlvd_in_reg.sv
// ----------------------------------------------------------------------------
// stlvd_in_reg
// input register holding one item for the deframer core
// ----------------------------------------------------------------------------
`default_nettype none

module stlvd_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stlvd_pkg::in_item_t in_item,
  output logic                    item_valid,
  output stlvd_pkg::in_item_t     item,
  input  wire logic               take
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stlvd_core.sv
// ----------------------------------------------------------------------------
// stlvd_core
// header, marker and body tracking; while fire is high, one item per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stlvd_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire stlvd_pkg::in_item_t item,
  output logic                     res_valid,
  output stlvd_pkg::res_t          res
);

  stlvd_pkg::phase_t                   phase, phase_next;
  logic [stlvd_pkg::LEN_W-1:0]         record_length, record_length_next;
  logic [stlvd_pkg::LEN_W-1:0]         record_position, record_position_next;
  logic [stlvd_pkg::CNT_W-1:0]         header_count, header_count_next;
  logic [stlvd_pkg::TYPE_W-1:0]        type_capture, type_capture_next;
  logic [stlvd_pkg::SS_W-1:0]          short_size, short_size_next;
  logic [stlvd_pkg::XS_W-1:0]          extended_size, extended_size_next;
  logic [stlvd_pkg::LEN_W-1:0]         body_len, body_len_next;
  logic [stlvd_pkg::OFF_W-1:0]         body_offset, body_offset_next;

  logic                                is_start;
  logic [stlvd_pkg::LEN_W-1:0]         len_clamped;
  logic [stlvd_pkg::LEN_W-1:0]         pos_inc;
  logic [stlvd_pkg::LEN_W-1:0]         left_after;
  logic                                too_few;
  logic                                hdr_last;
  logic                                xs_last;
  logic                                body_last;
  logic                                is_marker;
  logic [stlvd_pkg::SS_W-1:0]          short_full;
  logic [stlvd_pkg::XS_W-1:0]          sz;
  logic                                overrun;
  logic [stlvd_pkg::LEN_W-1:0]         sz_sat;
  logic [stlvd_pkg::TYPE_W-1:0]        type_put;
  logic [stlvd_pkg::XS_W-1:0]          xs_put;

  assign is_start    = (item.cmd == stlvd_pkg::CMD_START);
  assign len_clamped = (item.record_len > stlvd_pkg::MAX_RECORD_LEN) ?
                       stlvd_pkg::MAX_RECORD_LEN : item.record_len;
  assign pos_inc     = record_position + stlvd_pkg::LEN_W'(1);
  assign left_after  = record_length - pos_inc;
  assign too_few     = left_after < stlvd_pkg::HDR_BYTES;
  assign hdr_last    = header_count == stlvd_pkg::HDR_LAST;
  assign xs_last     = header_count == stlvd_pkg::XSIZE_LAST;
  assign body_last   = ({1'b0, body_offset} + stlvd_pkg::LEN_W'(1)) == body_len;
  assign is_marker   = type_capture == stlvd_pkg::MARKER_TYPE;
  assign short_full  = {item.data_byte, short_size[7:0]};
  assign sz          = (extended_size != '0) ? extended_size
                                             : {{(stlvd_pkg::XS_W-stlvd_pkg::SS_W){1'b0}},
                                                short_full};
  assign overrun     = sz > {{(stlvd_pkg::XS_W-stlvd_pkg::LEN_W){1'b0}}, left_after};
  assign sz_sat      = (|sz[stlvd_pkg::XS_W-1:stlvd_pkg::LEN_W]) ? stlvd_pkg::LEN_SAT
                                                                 : sz[stlvd_pkg::LEN_W-1:0];

  always_comb begin
    type_put = type_capture;
    type_put[header_count[1:0]*8 +: 8] = item.data_byte;
    xs_put = extended_size;
    xs_put[header_count[1:0]*8 +: 8] = item.data_byte;
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (is_start) begin
        phase_next = (len_clamped < stlvd_pkg::HDR_BYTES) ? stlvd_pkg::PH_DONE
                                                          : stlvd_pkg::PH_HEADER;
      end else begin
        unique case (phase)
          stlvd_pkg::PH_HEADER: begin
            if (hdr_last) begin
              if (is_marker) begin
                if (short_full != stlvd_pkg::MARKER_SIZE) begin
                  phase_next = stlvd_pkg::PH_DONE;
                end else if (left_after < stlvd_pkg::XSIZE_BYTES) begin
                  phase_next = stlvd_pkg::PH_DONE;
                end else begin
                  phase_next = stlvd_pkg::PH_XSIZE;
                end
              end else if (overrun) begin
                phase_next = stlvd_pkg::PH_DONE;
              end else if (sz == '0) begin
                phase_next = too_few ? stlvd_pkg::PH_DONE : stlvd_pkg::PH_HEADER;
              end else begin
                phase_next = stlvd_pkg::PH_BODY;
              end
            end
          end
          stlvd_pkg::PH_XSIZE: begin
            if (xs_last) begin
              phase_next = too_few ? stlvd_pkg::PH_DONE : stlvd_pkg::PH_HEADER;
            end
          end
          stlvd_pkg::PH_BODY: begin
            if (body_last) begin
              phase_next = too_few ? stlvd_pkg::PH_DONE : stlvd_pkg::PH_HEADER;
            end
          end
          stlvd_pkg::PH_IDLE, stlvd_pkg::PH_DONE: begin
            phase_next = phase;
          end
          default: begin
            phase_next = stlvd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    record_length_next   = record_length;
    record_position_next = record_position;
    header_count_next    = header_count;
    type_capture_next    = type_capture;
    short_size_next      = short_size;
    extended_size_next   = extended_size;
    body_len_next        = body_len;
    body_offset_next     = body_offset;
    res_valid            = 1'b0;
    res.kind             = stlvd_pkg::KIND_BODY;
    res.sub_type         = type_capture;
    res.sub_len          = '0;
    res.byte_offset      = '0;
    res.byte_value       = '0;
    res.last_of_sub      = 1'b0;

    if (is_start) begin
      record_length_next   = len_clamped;
      record_position_next = '0;
      extended_size_next   = '0;
      header_count_next    = '0;
      type_capture_next    = '0;
      short_size_next      = '0;
      body_offset_next     = '0;
      body_len_next        = '0;
    end else begin
      unique case (phase)
        stlvd_pkg::PH_HEADER: begin
          record_position_next = pos_inc;
          header_count_next    = header_count + stlvd_pkg::CNT_W'(1);
          if (header_count < stlvd_pkg::TYPE_BYTES) begin
            type_capture_next = type_put;
          end else if (!hdr_last) begin
            short_size_next = {8'd0, item.data_byte};
          end else begin
            short_size_next   = short_full;
            header_count_next = '0;
            if (is_marker) begin
              if (short_full != stlvd_pkg::MARKER_SIZE) begin
                res_valid   = 1'b1;
                res.kind    = stlvd_pkg::KIND_BAD_SIZE;
                res.sub_len = stlvd_pkg::LEN_W'(short_full);
              end else if (left_after < stlvd_pkg::XSIZE_BYTES) begin
                res_valid   = 1'b1;
                res.kind    = stlvd_pkg::KIND_TRUNC;
                res.sub_len = stlvd_pkg::LEN_W'(short_full);
              end else begin
                extended_size_next = '0;
              end
            end else begin
              extended_size_next = '0;
              if (overrun) begin
                res_valid   = 1'b1;
                res.kind    = stlvd_pkg::KIND_OVERRUN;
                res.sub_len = sz_sat;
              end else if (sz == '0) begin
                res_valid         = 1'b1;
                res.kind          = stlvd_pkg::KIND_EMPTY;
                res.last_of_sub   = 1'b1;
                type_capture_next = '0;
                short_size_next   = '0;
              end else begin
                body_len_next    = sz[stlvd_pkg::LEN_W-1:0];
                body_offset_next = '0;
              end
            end
          end
        end
        stlvd_pkg::PH_XSIZE: begin
          record_position_next = pos_inc;
          header_count_next    = header_count + stlvd_pkg::CNT_W'(1);
          extended_size_next   = xs_put;
          if (xs_last) begin
            header_count_next = '0;
            type_capture_next = '0;
            short_size_next   = '0;
            if (too_few) begin
              extended_size_next = '0;
            end
          end
        end
        stlvd_pkg::PH_BODY: begin
          record_position_next = pos_inc;
          res_valid            = 1'b1;
          res.kind             = stlvd_pkg::KIND_BODY;
          res.sub_len          = body_len;
          res.byte_offset      = body_offset;
          res.byte_value       = item.data_byte;
          res.last_of_sub      = body_last;
          body_offset_next     = body_offset + stlvd_pkg::OFF_W'(1);
          if (body_last) begin
            header_count_next = '0;
            type_capture_next = '0;
            short_size_next   = '0;
          end
        end
        stlvd_pkg::PH_IDLE, stlvd_pkg::PH_DONE: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= stlvd_pkg::PH_IDLE;
      record_length   <= '0;
      record_position <= '0;
      header_count    <= '0;
      type_capture    <= '0;
      short_size      <= '0;
      extended_size   <= '0;
      body_len        <= '0;
      body_offset     <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      record_length   <= record_length_next;
      record_position <= record_position_next;
      header_count    <= header_count_next;
      type_capture    <= type_capture_next;
      short_size      <= short_size_next;
      extended_size   <= extended_size_next;
      body_len        <= body_len_next;
      body_offset     <= body_offset_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stlvd_out_skid.sv
// ----------------------------------------------------------------------------
// stlvd_out_skid
// result register with a skid entry towards the master side
// ----------------------------------------------------------------------------
`default_nettype none

module stlvd_out_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 ready,
  input  wire stlvd_pkg::res_t push_res,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output stlvd_pkg::res_t      out_res
);

  logic            skid_valid;
  stlvd_pkg::res_t skid_res;
  logic            load;

  assign ready = !skid_valid;
  assign load  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/subrecord_tlv_deframer.sv
// ----------------------------------------------------------------------------
// subrecord_tlv_deframer
// splits a record payload byte stream into typed subrecord body bytes
// ----------------------------------------------------------------------------
// One item is taken every cycle while the master side keeps up. A start item
// (tuser 0) gives the record length; each payload byte (tuser 1) yields at
// most one result: a body byte, an empty-subrecord notice or an error, after
// which the record's remaining bytes are dropped. An item passes an input
// register, a registered update of the header and body counters, and a
// result register with a skid entry before its result is presented on the
// master side. While one result waits on a stalled master side, the next
// result goes to the skid entry and the slave side then waits until the
// master side takes a transaction. Bytes that leave fewer than six in the
// record at a subrecord boundary are skipped silently.
`default_nettype none

module subrecord_tlv_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // record_len, data_byte
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // sub_type, sub_len, byte_offset, byte_value
  output logic [2:0]       m_tuser,   // kind
  output logic             m_tlast    // last_of_sub
);

  stlvd_pkg::in_data_t in_data;
  stlvd_pkg::in_item_t in_item;
  stlvd_pkg::in_item_t item;
  stlvd_pkg::res_t     res;
  stlvd_pkg::res_t     out_res;
  stlvd_pkg::out_data_t out_data;
  logic                item_valid;
  logic                res_valid;
  logic                out_ready;
  logic                fire;

  assign in_data            = stlvd_pkg::in_data_t'(s_tdata);
  assign in_item.cmd        = stlvd_pkg::cmd_t'(s_tuser);
  assign in_item.record_len = in_data.record_len;
  assign in_item.data_byte  = in_data.data_byte;

  assign fire = item_valid && out_ready;

  stlvd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (fire)
  );

  stlvd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  stlvd_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .ready     (out_ready),
    .push_res  (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign out_data.pad         = '0;
  assign out_data.byte_value  = out_res.byte_value;
  assign out_data.byte_offset = out_res.byte_offset;
  assign out_data.sub_len     = out_res.sub_len;
  assign out_data.sub_type    = out_res.sub_type;

  assign m_tdata = out_data;
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_of_sub;

endmodule

`default_nettype wire

>>> hw/rtl/stlvd_checker.sv
// ----------------------------------------------------------------------------
// stlvd_checker
// port-level checks of the subrecord tlv deframer results
// ----------------------------------------------------------------------------
`default_nettype none

`include "subrecord_tlv_deframer_defines.svh"

module stlvd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  stlvd_pkg::out_data_t od;
  logic                 is_body;
  logic                 is_empty;
  logic                 is_error;
  logic [stlvd_pkg::LEN_W-1:0] off_inc;

  assign od       = stlvd_pkg::out_data_t'(m_tdata);
  assign is_body  = m_tvalid && (m_tuser == stlvd_pkg::KIND_BODY);
  assign is_empty = m_tvalid && (m_tuser == stlvd_pkg::KIND_EMPTY);
  assign is_error = m_tvalid && !is_body && !is_empty;
  assign off_inc  = {1'b0, od.byte_offset} + stlvd_pkg::LEN_W'(1);

  // stalled results hold
  `STLVD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // nothing waiting on the master side leaves the slave side open
  `STLVD_ASSERT_IMP(a_ready, !m_tvalid, s_tready)

  // body bytes stay inside the subrecord and flag its final byte
  `STLVD_ASSERT_IMP(a_body_last, is_body, (off_inc <= od.sub_len) && (m_tlast == (off_inc == od.sub_len)))

  // empty notice is last, zero length, no byte
  `STLVD_ASSERT_IMP(a_empty, is_empty, m_tlast && od.sub_len == '0 && od.byte_offset == '0 && od.byte_value == '0)

  // errors never close a subrecord and carry no byte
  `STLVD_ASSERT_IMP(a_error, is_error, !m_tlast && od.byte_offset == '0 && od.byte_value == '0)

endmodule

bind subrecord_tlv_deframer stlvd_checker u_stlvd_checker (.*);

`default_nettype wire

>>> test/subrecord_tlv_deframer_tb.sv
// ----------------------------------------------------------------------------
// subrecord_tlv_deframer_tb
// self-checking bench for the subrecord tlv deframer
// ----------------------------------------------------------------------------
// Records are built from typed subrecords, some with an extended-size marker,
// and sent as a start transaction and a run of payload bytes. Broken records,
// noise and abandoned records are mixed in. A walker in the bench follows the
// payload and queues the expected results, which are checked field by field
// as they leave the block, under several sender and receiver idling mixes.
`default_nettype none

module subrecord_tlv_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // record_len, data_byte
  logic        s_tuser = 1'b0;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;         // sub_type, sub_len, byte_offset, byte_value
  logic [2:0]  m_tuser;         // kind
  logic        m_tlast;         // last_of_sub

  subrecord_tlv_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // walker state
  logic [stlvd_pkg::LEN_W-1:0]  rec_len = '0;
  logic [stlvd_pkg::LEN_W-1:0]  rec_pos = '0;
  stlvd_pkg::phase_t            walk_ph = stlvd_pkg::PH_IDLE;
  logic [3:0]                   hdr_cnt = '0;
  logic [stlvd_pkg::TYPE_W-1:0] walk_type = '0;
  logic [stlvd_pkg::SS_W-1:0]   short_sz = '0;
  logic [stlvd_pkg::XS_W-1:0]   ext_pending = '0;
  logic [stlvd_pkg::LEN_W-1:0]  body_left = '0;
  logic [stlvd_pkg::OFF_W-1:0]  body_off = '0;
  logic                         item_used;

  stlvd_pkg::res_t pending_results[$];
  logic [7:0]      pay_q[$];
  int              live_items = 0;
  int              mismatches = 0;
  int              send_idle = 0;
  int              recv_stall = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [stlvd_pkg::LEN_W-1:0] bytes_left();
    return (rec_pos >= rec_len) ? '0 : rec_len - rec_pos;
  endfunction

  task automatic open_subrecord();
    hdr_cnt = '0;
    walk_type = '0;
    short_sz = '0;
    if (bytes_left() < stlvd_pkg::HDR_BYTES) begin
      walk_ph = stlvd_pkg::PH_DONE;
      ext_pending = '0;
    end else begin
      walk_ph = stlvd_pkg::PH_HEADER;
    end
  endtask

  task automatic post_result(input stlvd_pkg::kind_t k, input logic [32:0] len,
                             input logic [stlvd_pkg::OFF_W-1:0] off,
                             input logic [7:0] v, input logic last);
    stlvd_pkg::res_t r;
    r.kind = k;
    r.sub_type = walk_type;
    r.sub_len = (len > 33'(stlvd_pkg::LEN_SAT)) ? stlvd_pkg::LEN_SAT
                                                : len[stlvd_pkg::LEN_W-1:0];
    r.byte_offset = off;
    r.byte_value = v;
    r.last_of_sub = last;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic deframe_item(input stlvd_pkg::cmd_t c,
                              input logic [stlvd_pkg::LEN_W-1:0] len,
                              input logic [7:0] b);
    logic [32:0]                 sz;
    logic [stlvd_pkg::LEN_W-1:0] total;
    logic                        last;
    item_used = 1'b0;
    if (c == stlvd_pkg::CMD_START) begin
      item_used = 1'b1;
      rec_len = (len > stlvd_pkg::MAX_RECORD_LEN) ? stlvd_pkg::MAX_RECORD_LEN : len;
      rec_pos = '0;
      ext_pending = '0;
      body_left = '0;
      body_off = '0;
      open_subrecord();
    end else if (walk_ph == stlvd_pkg::PH_HEADER || walk_ph == stlvd_pkg::PH_XSIZE ||
                 walk_ph == stlvd_pkg::PH_BODY) begin
      item_used = 1'b1;
      rec_pos = rec_pos + 1'b1;
      unique case (walk_ph)
        stlvd_pkg::PH_HEADER: begin
          if (hdr_cnt < 4) walk_type = walk_type | (32'(b) << (8 * hdr_cnt));
          else if (hdr_cnt == 4) short_sz = {8'h00, b};
          else short_sz = {b, short_sz[7:0]};
          hdr_cnt = hdr_cnt + 1'b1;
          if (hdr_cnt == stlvd_pkg::HDR_BYTES) begin
            hdr_cnt = '0;
            if (walk_type == stlvd_pkg::MARKER_TYPE) begin
              if (short_sz != stlvd_pkg::MARKER_SIZE) begin
                walk_ph = stlvd_pkg::PH_DONE;
                post_result(stlvd_pkg::KIND_BAD_SIZE, 33'(short_sz), '0, '0, 1'b0);
              end else if (bytes_left() < stlvd_pkg::XSIZE_BYTES) begin
                walk_ph = stlvd_pkg::PH_DONE;
                post_result(stlvd_pkg::KIND_TRUNC, 33'(short_sz), '0, '0, 1'b0);
              end else begin
                ext_pending = '0;
                walk_ph = stlvd_pkg::PH_XSIZE;
              end
            end else begin
              sz = (ext_pending != '0) ? 33'(ext_pending) : 33'(short_sz);
              ext_pending = '0;
              if (sz > 33'(bytes_left())) begin
                walk_ph = stlvd_pkg::PH_DONE;
                post_result(stlvd_pkg::KIND_OVERRUN, sz, '0, '0, 1'b0);
              end else if (sz == '0) begin
                post_result(stlvd_pkg::KIND_EMPTY, '0, '0, '0, 1'b1);
                open_subrecord();
              end else begin
                body_left = sz[stlvd_pkg::LEN_W-1:0];
                body_off = '0;
                walk_ph = stlvd_pkg::PH_BODY;
              end
            end
          end
        end
        stlvd_pkg::PH_XSIZE: begin
          ext_pending = ext_pending | (32'(b) << (8 * hdr_cnt[1:0]));
          hdr_cnt = hdr_cnt + 1'b1;
          if (hdr_cnt >= stlvd_pkg::XSIZE_BYTES) open_subrecord();
        end
        default: begin
          total = stlvd_pkg::LEN_W'(body_off) + body_left;
          last = (body_left <= 1);
          post_result(stlvd_pkg::KIND_BODY, 33'(total), body_off, b, last);
          body_off = body_off + 1'b1;
          if (body_left != '0) body_left = body_left - 1'b1;
          if (last) open_subrecord();
        end
      endcase
    end
  endtask

  task automatic send_item(input stlvd_pkg::cmd_t c,
                           input logic [stlvd_pkg::LEN_W-1:0] len,
                           input logic [7:0] b);
    stlvd_pkg::in_data_t d;
    d = '0;
    d.record_len = len;
    d.data_byte = b;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_item(c, len, b);
    if (item_used) live_items++;
  endtask

  task automatic send_record(input logic [stlvd_pkg::LEN_W-1:0] len);
    send_item(stlvd_pkg::CMD_START, len, 8'($urandom));
    foreach (pay_q[i]) send_item(stlvd_pkg::CMD_BYTE, stlvd_pkg::LEN_W'($urandom), pay_q[i]);
  endtask

  task automatic put_byte(input logic [7:0] v);
    pay_q.insert(pay_q.size(), v);
  endtask

  task automatic put_header(input logic [31:0] t, input logic [15:0] sz);
    put_byte(t[7:0]);
    put_byte(t[15:8]);
    put_byte(t[23:16]);
    put_byte(t[31:24]);
    put_byte(sz[7:0]);
    put_byte(sz[15:8]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) put_byte(v[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  function automatic logic [31:0] rand_type();
    return ($urandom_range(3) == 0) ? {8'($urandom), 24'h585858} : 32'($urandom);
  endfunction

  task automatic put_subrecord();
    logic [31:0] ext;
    logic [15:0] ssz;
    if ($urandom_range(99) < 20) begin
      ext = ($urandom_range(3) == 0) ? '0 : 32'($urandom_range(1, 24));
      put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
      put_le32(ext);
      ssz = (ext != '0) ? 16'($urandom) : 16'($urandom_range(8));
      put_header(rand_type(), ssz);
      put_noise((ext != '0) ? int'(ext) : int'(ssz));
    end else begin
      ssz = ($urandom_range(4) == 0) ? '0 : 16'($urandom_range(1, 12));
      put_header(rand_type(), ssz);
      put_noise(int'(ssz));
    end
  endtask

  task automatic random_record();
    logic [stlvd_pkg::LEN_W-1:0] len;
    int                          variant;
    pay_q.delete();
    variant = int'($urandom_range(99));
    repeat ($urandom_range(1, 4)) put_subrecord();
    if (variant < 75) begin
      if ($urandom_range(3) == 0) put_noise(int'($urandom_range(1, 5)));
      len = stlvd_pkg::LEN_W'(pay_q.size());
    end else begin
      unique case (variant % 6)
        0: len = stlvd_pkg::LEN_W'($urandom_range(pay_q.size()));
        1: len = stlvd_pkg::LEN_W'(pay_q.size()) + stlvd_pkg::LEN_W'($urandom_range(1, 40));
        2: begin
          put_header(stlvd_pkg::MARKER_TYPE, 16'($urandom));
          put_noise(int'($urandom_range(8)));
          len = stlvd_pkg::LEN_W'(pay_q.size());
        end
        3: begin
          if ($urandom_range(1) != 0) begin
            put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
            put_le32($urandom);
          end
          put_header(rand_type(), 16'($urandom));
          put_noise(int'($urandom_range(8)));
          len = stlvd_pkg::LEN_W'(pay_q.size());
        end
        4: begin
          put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
          put_noise(int'($urandom_range(3)));
          len = stlvd_pkg::LEN_W'(pay_q.size());
        end
        default: begin
          pay_q.delete();
          put_noise(int'($urandom_range(40)));
          len = ($urandom_range(1) != 0) ? stlvd_pkg::LEN_W'(pay_q.size())
                                         : stlvd_pkg::LEN_W'($urandom);
        end
      endcase
    end
    send_record(len);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t %s: expected %h, got %h", $realtime, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    stlvd_pkg::out_data_t od;
    stlvd_pkg::res_t      want;
    if (!rst && m_tvalid && m_tready) begin
      od = stlvd_pkg::out_data_t'(m_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t unexpected transaction, kind %0d", $realtime, m_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_tuser));
        check_field("sub_type", want.sub_type, od.sub_type);
        check_field("sub_len", 32'(want.sub_len), 32'(od.sub_len));
        check_field("byte_offset", 32'(want.byte_offset), 32'(od.byte_offset));
        check_field("byte_value", 32'(want.byte_value), 32'(od.byte_value));
        check_field("last_of_sub", 32'(want.last_of_sub), 32'(m_tlast));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic test_stray_bytes();
    send_item(stlvd_pkg::CMD_BYTE, stlvd_pkg::LEN_SAT, 8'hFF);
    send_item(stlvd_pkg::CMD_BYTE, '0, 8'h00);
  endtask

  task automatic test_record_edges();
    pay_q.delete();
    put_header(32'h4443_4241, 16'h0000);
    put_byte(8'hFF);
    put_byte(8'h00);
    send_record(stlvd_pkg::LEN_W'(8));
    send_item(stlvd_pkg::CMD_BYTE, '0, 8'h5A);
    send_item(stlvd_pkg::CMD_START, '0, 8'hFF);
    send_item(stlvd_pkg::CMD_BYTE, stlvd_pkg::LEN_SAT, 8'hFF);
  endtask

  task automatic test_marker_errors();
    pay_q.delete();
    put_header(stlvd_pkg::MARKER_TYPE, 16'hFFFF);
    send_record(stlvd_pkg::LEN_SAT);
    pay_q.delete();
    put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
    put_byte(8'h01);
    send_record(stlvd_pkg::LEN_W'(8));
  endtask

  task automatic test_overrun();
    pay_q.delete();
    put_header(32'h3132_3334, 16'h0001);
    send_record(stlvd_pkg::LEN_W'(6));
    pay_q.delete();
    put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
    put_le32(32'hFFFF_FFFF);
    put_header(32'h3132_3334, 16'h0000);
    send_record(stlvd_pkg::LEN_W'(16));
  endtask

  task automatic test_restart();
    pay_q.delete();
    put_header(stlvd_pkg::MARKER_TYPE, stlvd_pkg::MARKER_SIZE);
    put_le32(32'd3);
    send_record(stlvd_pkg::LEN_W'(40));
    pay_q.delete();
    put_header(32'h4142_4344, 16'h0003);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    send_record(stlvd_pkg::LEN_W'(9));
  endtask

  task automatic test_random_records(input int goal, input int idle_pct,
                                     input int stall_pct);
    int first;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    first = live_items;
    while (live_items - first < goal) random_record();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_stray_bytes();
    test_record_edges();
    test_marker_errors();
    test_overrun();
    test_restart();
    test_random_records(420, 0, 0);
    test_random_records(420, 84, 0);
    test_random_records(420, 0, 84);
    test_random_records(420, 6, 6);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> subrecord_tlv_deframer.f
+incdir+hw/rtl
hw/rtl/stlvd_pkg.sv
hw/rtl/stlvd_in_reg.sv
hw/rtl/stlvd_core.sv
hw/rtl/stlvd_out_skid.sv
hw/rtl/subrecord_tlv_deframer.sv
hw/rtl/stlvd_checker.sv
test/subrecord_tlv_deframer_tb.sv
